### hdl/bcp_pkg.sv
// Package for the Pascal-triangle binomial coefficient block.
// Holds field widths, the controller state type and the cell link type.
// No dependencies.
package bcp_pkg;

	localparam int ORDER_W = 6;
	localparam int COEF_W  = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} bcp_state_t;

	typedef struct packed {
		logic              act;
		logic              ovf;
		logic [COEF_W-1:0] sum;
	} bcp_link_t;

endpackage

### hdl/binomial_coefficient_pascal.sv
// Top level of the Pascal-triangle binomial coefficient block.
// Instantiates the chain of bcp_cell entries and the sequencing controller.
// Depends on bcp_pkg and bcp_cell.
//
// A transaction starts when start is high while busy is low; one result follows, shown on
// coefficient and overflow for the single cycle that done is high, and the receiver cannot
// stall it. When choose is above order, zero, or equal to order, or order is not below
// MAX_ORDER, done rises in the cycle after start and busy stays low. Otherwise the row of
// MAX_ORDER-1 cells runs a skewed wavefront, one column pass entering the chain per cycle,
// and the result is taken from the cell that holds C(m, n) once the last pass has left it;
// busy is high while the controller is in its run and result states.
module binomial_coefficient_pascal import bcp_pkg::*; #(
	parameter int MAX_ORDER = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ORDER_W-1:0] order,
	input  logic [ORDER_W-1:0] choose,
	output logic               busy,
	output logic               done,
	output logic [COEF_W-1:0]  coefficient,
	output logic               overflow
);

	localparam int IDX_W = (MAX_ORDER > 2) ? $clog2(MAX_ORDER) : 1;

	bcp_state_t         state_q, state_d;
	logic [ORDER_W-1:0] m_q;
	logic [ORDER_W-1:0] n_q;
	logic [ORDER_W-1:0] d_q;
	logic [ORDER_W-1:0] cnt_q;
	logic               done_q;
	logic [COEF_W-1:0]  coef_q;
	logic               ovf_q;

	logic               accept;
	logic               trivial;
	logic               load;
	logic               act;
	logic               last;

	bcp_link_t          links [MAX_ORDER];

	assign accept  = start && (state_q == ST_IDLE);
	assign trivial = (choose > order) || (choose == '0) || (choose == order)
		|| (32'(order) >= MAX_ORDER);
	assign last    = ({1'b0, cnt_q} + (ORDER_W+1)'(2)) >= {1'b0, m_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !trivial) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		load = 1'b0;
		act  = 1'b0;
		busy = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				load = accept && !trivial;
			end
			ST_RUN: begin
				act  = cnt_q < n_q;
				busy = 1'b1;
			end
			ST_DONE: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && trivial) || (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_q   <= order;
			n_q   <= choose;
			d_q   <= order - choose;
			cnt_q <= ORDER_W'(1);
		end else if (state_q == ST_RUN) begin
			cnt_q <= cnt_q + ORDER_W'(1);
		end
		if (accept && trivial) begin
			if (choose > order) begin
				coef_q <= '0;
				ovf_q  <= 1'b0;
			end else if ((choose == '0) || (choose == order)) begin
				coef_q <= COEF_W'(1);
				ovf_q  <= 1'b0;
			end else begin
				coef_q <= {COEF_W{1'b1}};
				ovf_q  <= 1'b1;
			end
		end else if (state_q == ST_DONE) begin
			coef_q <= links[IDX_W'(d_q)].sum;
			ovf_q  <= links[IDX_W'(d_q)].ovf;
		end
	end

	assign links[0].act = act;
	assign links[0].ovf = 1'b0;
	assign links[0].sum = COEF_W'(1);

	for (genvar k = 1; k < MAX_ORDER; k++) begin : g_cell
		bcp_cell #(
			.IDX (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (load),
			.diff   (order - choose),
			.link_i (links[k-1]),
			.link_o (links[k])
		);
	end

	assign done        = done_q;
	assign coefficient = coef_q;
	assign overflow    = ovf_q;

endmodule

### hdl/bcp_cell.sv
// One cell of the Pascal-triangle chain: holds one entry of the work row.
// Adds its left neighbor's entry on each active wavefront step, if its index is at most order - choose.
// Depends on bcp_pkg.
module bcp_cell import bcp_pkg::*; #(
	parameter int IDX = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [ORDER_W-1:0] diff,
	input  bcp_link_t          link_i,
	output bcp_link_t          link_o
);

	logic              act_q;
	logic              live_q;
	logic              ovf_q;
	logic [COEF_W-1:0] sum_q;
	logic [COEF_W:0]   add;

	assign add = {1'b0, link_i.sum} + {1'b0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			live_q <= 1'b0;
		end else begin
			act_q <= link_i.act & ~load;
			if (load) begin
				live_q <= (IDX <= 32'(diff));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_q <= COEF_W'(IDX + 1);
			ovf_q <= 1'b0;
		end else if (link_i.act && live_q) begin
			sum_q <= add[COEF_W] ? {COEF_W{1'b1}} : add[COEF_W-1:0];
			ovf_q <= ovf_q | link_i.ovf | add[COEF_W];
		end
	end

	assign link_o.act = act_q;
	assign link_o.ovf = ovf_q;
	assign link_o.sum = sum_q;

endmodule

### test/tb_binomial_coefficient_pascal.sv
// Self-checking testbench for binomial_coefficient_pascal: sends (order, choose) pairs and
// compares each coefficient and overflow flag with a local Pascal-recurrence prediction.
// Depends on bcp_pkg and the binomial_coefficient_pascal RTL.
`timescale 1ns / 1ps

module tb_binomial_coefficient_pascal;
	import bcp_pkg::*;

	localparam int MAX_ORDER   = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = MAX_ORDER + 8;
	localparam int PRINT_CAP   = 40;

	typedef struct {
		logic [ORDER_W-1:0] m;
		logic [ORDER_W-1:0] n;
		logic [COEF_W-1:0]  coef;
		logic               ovf;
	} binom_expect_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic [ORDER_W-1:0] order;
	logic [ORDER_W-1:0] choose;
	logic               busy;
	logic               done;
	logic [COEF_W-1:0]  coefficient;
	logic               overflow;

	binom_expect_t pending_coefs[$];
	int            mismatches;
	int            requests_sent;
	int            results_seen;
	int            trivial_sent;
	int            cycle_count;

	binomial_coefficient_pascal #(.MAX_ORDER(MAX_ORDER)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.order       (order),
		.choose      (choose),
		.busy        (busy),
		.done        (done),
		.coefficient (coefficient),
		.overflow    (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_coefs.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic binom_expect_t pascal_coefficient(logic [ORDER_W-1:0] m,
		logic [ORDER_W-1:0] n);
		binom_expect_t r;
		logic [COEF_W-1:0] row [0:MAX_ORDER-1];
		logic [COEF_W:0]   s;
		int                d;
		r.m    = m;
		r.n    = n;
		r.ovf  = 1'b0;
		r.coef = '0;
		if (n > m) begin
			r.coef = '0;
		end else if (n == 0 || n == m) begin
			r.coef = 1;
		end else if (int'(m) >= MAX_ORDER) begin
			r.coef = '1;
			r.ovf  = 1'b1;
		end else begin
			d = int'(m) - int'(n);
			for (int i = 0; i <= d; i++)
				row[i] = COEF_W'(i + 1);
			for (int j = 1; j < int'(n); j++) begin
				for (int i = 1; i <= d; i++) begin
					s = {1'b0, row[i-1]} + {1'b0, row[i]};
					if (s[COEF_W]) begin
						row[i] = '1;
						r.ovf  = 1'b1;
					end else begin
						row[i] = s[COEF_W-1:0];
					end
				end
			end
			r.coef = row[d];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input binom_expect_t e,
		input logic [COEF_W-1:0] got_coef, input logic got_ovf);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH %s: C(%0d,%0d) got %0d ovf %0b, want %0d ovf %0b", what,
				e.m, e.n, got_coef, got_ovf, e.coef, e.ovf);
		mismatches++;
	endtask

	always @(posedge clk) begin
		binom_expect_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_coefs.size() == 0) begin
				e.m    = '0;
				e.n    = '0;
				e.coef = '0;
				e.ovf  = 1'b0;
				report_mismatch("unexpected result", e, coefficient, overflow);
			end else begin
				e = pending_coefs.pop_front();
				if (coefficient !== e.coef)
					report_mismatch("coefficient", e, coefficient, overflow);
				if (overflow !== e.ovf)
					report_mismatch("overflow", e, coefficient, overflow);
			end
		end
	end

	function automatic int idle_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		else if (p < 85)
			return $urandom_range(1, 3);
		else if (p < 96)
			return $urandom_range(4, 70);
		else
			return $urandom_range(71, 150);
	endfunction

	// hold start until a transaction is taken, then drop it only for a real gap
	task automatic send_request(input logic [ORDER_W-1:0] m, input logic [ORDER_W-1:0] n,
		input int gap);
		start  <= 1'b1;
		order  <= m;
		choose <= n;
		do
			@(posedge clk);
		while (busy);
		pending_coefs.push_back(pascal_coefficient(m, n));
		requests_sent++;
		if (n > m || n == 0 || n == m)
			trivial_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_directed_corners();
		logic [ORDER_W-1:0] pairs [0:21][0:1];
		pairs = '{
			'{6'd0, 6'd0}, '{6'd63, 6'd63}, '{6'd63, 6'd0}, '{6'd0, 6'd63},
			'{6'd5, 6'd6}, '{6'd62, 6'd63}, '{6'd1, 6'd0}, '{6'd1, 6'd1},
			'{6'd2, 6'd1}, '{6'd3, 6'd1}, '{6'd3, 6'd2}, '{6'd63, 6'd1},
			'{6'd63, 6'd62}, '{6'd63, 6'd31}, '{6'd63, 6'd32}, '{6'd62, 6'd31},
			'{6'd63, 6'd30}, '{6'd42, 6'd21}, '{6'd10, 6'd3}, '{6'd4, 6'd2},
			'{6'd21, 6'd42}, '{6'd32, 6'd16}
		};
		foreach (pairs[i])
			send_request(pairs[i][0], pairs[i][1], (i % 3 == 0) ? 0 : idle_gap());
	endtask

	task automatic test_valid_pairs(input int count);
		logic [ORDER_W-1:0] m;
		logic [ORDER_W-1:0] n;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0)
				m = ORDER_W'($urandom_range(56, 63));
			else
				m = ORDER_W'($urandom_range(0, 63));
			n = ORDER_W'($urandom_range(0, m));
			send_request(m, n, idle_gap());
		end
	endtask

	task automatic test_small_orders(input int count);
		logic [ORDER_W-1:0] m;
		for (int i = 0; i < count; i++) begin
			m = ORDER_W'($urandom_range(0, 8));
			send_request(m, ORDER_W'($urandom_range(0, m + 1)), idle_gap());
		end
	endtask

	task automatic test_arbitrary_fields(input int count);
		for (int i = 0; i < count; i++)
			send_request(ORDER_W'($urandom()), ORDER_W'($urandom()), idle_gap());
	endtask

	task automatic test_back_to_back(input int count);
		logic [ORDER_W-1:0] m;
		for (int i = 0; i < count; i++) begin
			m = ORDER_W'($urandom());
			send_request(m, ($urandom_range(0, 3) == 0) ? ORDER_W'($urandom())
				: ORDER_W'($urandom_range(0, m)), 0);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         <= 1'b0;
		order         <= '0;
		choose        <= '0;
		mismatches    = 0;
		requests_sent = 0;
		results_seen  = 0;
		trivial_sent  = 0;
		cycle_count   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_valid_pairs(700);
		test_small_orders(200);
		test_arbitrary_fields(250);
		test_back_to_back(150);

		start <= 1'b0;
		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d requests (%0d trivial), checked %0d results, %0d mismatches",
			requests_sent, trivial_sent, results_seen, mismatches);
		$display("covered orders 0..63, choose above/at/below order, back-to-back and gaps");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hdl/bcp_pkg.sv
hdl/bcp_cell.sv
hdl/binomial_coefficient_pascal.sv
test/tb_binomial_coefficient_pascal.sv
